// ===== sv/toy_word_machine_executor_macros.svh =====
// Assertion macros shared by the word machine RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef TOY_WORD_MACHINE_EXECUTOR_MACROS_SVH
`define TOY_WORD_MACHINE_EXECUTOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TWM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TWM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/twm_pkg.sv =====
// Shared types, codes and the microprogram for the word machine executor.
// Depends on nothing; used by the sequencer, the datapath and the top level.
package twm_pkg;

    // Machine size.
    localparam int MEM_WORDS   = 100;
    localparam int BLOCK_WORDS = 10;
    localparam int MEM_AW      = $clog2(MEM_WORDS);
    localparam logic [6:0] MEM_LIMIT = 7'(MEM_WORDS);

    // Character constants.
    localparam logic [31:0] SPACES    = 32'h2020_2020;
    localparam logic [31:0] HALT_WORD = 32'h4830_3030;
    localparam logic [7:0]  CH_G  = 8'h47;
    localparam logic [7:0]  CH_P  = 8'h50;
    localparam logic [7:0]  CH_H  = 8'h48;
    localparam logic [7:0]  CH_L  = 8'h4C;
    localparam logic [7:0]  CH_R  = 8'h52;
    localparam logic [7:0]  CH_S  = 8'h53;
    localparam logic [7:0]  CH_C  = 8'h43;
    localparam logic [7:0]  CH_B  = 8'h42;
    localparam logic [7:0]  CH_T  = 8'h54;
    localparam logic [7:0]  CH_D  = 8'h44;
    localparam logic [7:0]  CH_0  = 8'h30;
    localparam logic [7:0]  CH_9  = 8'h39;

    // Item modes.
    localparam logic [2:0] MODE_LOAD  = 3'd0;
    localparam logic [2:0] MODE_START = 3'd1;
    localparam logic [2:0] MODE_EXEC  = 3'd2;
    localparam logic [2:0] MODE_CARD  = 3'd3;
    localparam logic [2:0] MODE_CLEAR = 3'd4;

    // Result status codes.
    localparam logic [2:0] ST_DONE  = 3'd0;
    localparam logic [2:0] ST_WAIT  = 3'd1;
    localparam logic [2:0] ST_PRINT = 3'd2;
    localparam logic [2:0] ST_HALT  = 3'd3;
    localparam logic [2:0] ST_BAD   = 3'd4;

    typedef logic [BLOCK_WORDS-1:0] t_seen;

    // Jump conditions.
    typedef enum logic [3:0] {
        C_NEVER, C_ALWAYS, C_ADDR_BAD, C_PENDING, C_IC_BAD, C_IS_GD, C_IS_PD, C_IS_H,
        C_IS_XR, C_BT_SKIP, C_OPND_BAD, C_BLK_BAD, C_CARD_FULL, C_PRINT_MORE, C_IS_L,
        C_IS_S
    } t_cond;

    // Datapath actions.
    typedef enum logic [4:0] {
        A_NONE, A_LOAD_WR, A_START, A_CLEAR, A_CARD_WR, A_CARD_END, A_FETCH, A_IR,
        A_GD, A_PD_INIT, A_PD_RD, A_PD_NEXT, A_OP_RD, A_LR, A_SR, A_CR, A_BT
    } t_act;

    localparam int U_W = 6;
    typedef logic [U_W-1:0] t_upc;

    // One control word of the microprogram.
    typedef struct packed {
        t_cond      cond;
        t_upc       target;
        logic       fin;
        t_act       act;
        logic       emit;
        logic [2:0] status;
    } t_uword;

    // Control from the sequencer to the datapath.
    typedef struct packed {
        logic       accept;
        logic       go;
        t_act       act;
        logic       emit;
        logic [2:0] status;
    } t_ctrl;

    // Status from the datapath back to the sequencer.
    typedef struct packed {
        logic addr_bad;
        logic pending;
        logic ic_bad;
        logic is_gd;
        logic is_pd;
        logic is_h;
        logic is_xr;
        logic bt_skip;
        logic opnd_bad;
        logic blk_bad;
        logic card_full;
        logic print_more;
        logic is_l;
        logic is_s;
        logic slot_free;
    } t_flags;

    // Microprogram step addresses.
    localparam t_upc U_IDLE    = 6'd0;
    localparam t_upc U_LD_CHK  = 6'd1;
    localparam t_upc U_LD_WR   = 6'd2;
    localparam t_upc U_ST      = 6'd3;
    localparam t_upc U_ST_END  = 6'd4;
    localparam t_upc U_CL      = 6'd5;
    localparam t_upc U_CL_END  = 6'd6;
    localparam t_upc U_CD_CHK  = 6'd7;
    localparam t_upc U_DONE    = 6'd8;
    localparam t_upc U_CD_WR   = 6'd9;
    localparam t_upc U_CD_TST  = 6'd10;
    localparam t_upc U_WAIT    = 6'd11;
    localparam t_upc U_CD_END  = 6'd12;
    localparam t_upc U_EX      = 6'd13;
    localparam t_upc U_EX_IC   = 6'd14;
    localparam t_upc U_FETCH   = 6'd15;
    localparam t_upc U_IR      = 6'd16;
    localparam t_upc U_DEC_GD  = 6'd17;
    localparam t_upc U_DEC_PD  = 6'd18;
    localparam t_upc U_DEC_H   = 6'd19;
    localparam t_upc U_DEC_XR  = 6'd20;
    localparam t_upc U_BT      = 6'd21;
    localparam t_upc U_BT_CHK  = 6'd22;
    localparam t_upc U_BT_DO   = 6'd23;
    localparam t_upc U_GD      = 6'd24;
    localparam t_upc U_GD_DO   = 6'd25;
    localparam t_upc U_PD      = 6'd26;
    localparam t_upc U_PD_INIT = 6'd27;
    localparam t_upc U_PD_RD   = 6'd28;
    localparam t_upc U_PD_EM   = 6'd29;
    localparam t_upc U_HALT    = 6'd30;
    localparam t_upc U_XR      = 6'd31;
    localparam t_upc U_XR_RD   = 6'd32;
    localparam t_upc U_XR_L    = 6'd33;
    localparam t_upc U_XR_S    = 6'd34;
    localparam t_upc U_CR      = 6'd35;
    localparam t_upc U_LR      = 6'd36;
    localparam t_upc U_SR      = 6'd37;
    localparam t_upc U_BAD     = 6'd38;

    function automatic t_uword mk(input t_cond c, input t_upc tgt, input logic fin,
                                  input t_act act, input logic emit,
                                  input logic [2:0] st);
        t_uword w;
        w.cond   = c;
        w.target = tgt;
        w.fin    = fin;
        w.act    = act;
        w.emit   = emit;
        w.status = st;
        return w;
    endfunction

    // The microprogram ROM.
    function automatic t_uword urom(input t_upc a);
        t_uword w;
        unique case (a)
            U_LD_CHK:  w = mk(C_ADDR_BAD,   U_BAD,   1'b0, A_NONE,     1'b0, ST_DONE);
            U_LD_WR:   w = mk(C_NEVER,      U_IDLE,  1'b1, A_LOAD_WR,  1'b1, ST_DONE);
            U_ST:      w = mk(C_NEVER,      U_IDLE,  1'b0, A_START,    1'b0, ST_DONE);
            U_ST_END:  w = mk(C_NEVER,      U_IDLE,  1'b1, A_NONE,     1'b1, ST_DONE);
            U_CL:      w = mk(C_NEVER,      U_IDLE,  1'b0, A_CLEAR,    1'b0, ST_DONE);
            U_CL_END:  w = mk(C_NEVER,      U_IDLE,  1'b1, A_NONE,     1'b1, ST_DONE);
            U_CD_CHK:  w = mk(C_PENDING,    U_CD_WR, 1'b0, A_NONE,     1'b0, ST_DONE);
            U_DONE:    w = mk(C_NEVER,      U_IDLE,  1'b1, A_NONE,     1'b1, ST_DONE);
            U_CD_WR:   w = mk(C_NEVER,      U_IDLE,  1'b0, A_CARD_WR,  1'b0, ST_DONE);
            U_CD_TST:  w = mk(C_CARD_FULL,  U_CD_END, 1'b0, A_NONE,    1'b0, ST_DONE);
            U_WAIT:    w = mk(C_NEVER,      U_IDLE,  1'b1, A_NONE,     1'b1, ST_WAIT);
            U_CD_END:  w = mk(C_NEVER,      U_IDLE,  1'b1, A_CARD_END, 1'b1, ST_DONE);
            U_EX:      w = mk(C_PENDING,    U_WAIT,  1'b0, A_NONE,     1'b0, ST_DONE);
            U_EX_IC:   w = mk(C_IC_BAD,     U_BAD,   1'b0, A_NONE,     1'b0, ST_DONE);
            U_FETCH:   w = mk(C_NEVER,      U_IDLE,  1'b0, A_FETCH,    1'b0, ST_DONE);
            U_IR:      w = mk(C_NEVER,      U_IDLE,  1'b0, A_IR,       1'b0, ST_DONE);
            U_DEC_GD:  w = mk(C_IS_GD,      U_GD,    1'b0, A_NONE,     1'b0, ST_DONE);
            U_DEC_PD:  w = mk(C_IS_PD,      U_PD,    1'b0, A_NONE,     1'b0, ST_DONE);
            U_DEC_H:   w = mk(C_IS_H,       U_HALT,  1'b0, A_NONE,     1'b0, ST_DONE);
            U_DEC_XR:  w = mk(C_IS_XR,      U_XR,    1'b0, A_NONE,     1'b0, ST_DONE);
            U_BT:      w = mk(C_BT_SKIP,    U_DONE,  1'b0, A_NONE,     1'b0, ST_DONE);
            U_BT_CHK:  w = mk(C_OPND_BAD,   U_BAD,   1'b0, A_NONE,     1'b0, ST_DONE);
            U_BT_DO:   w = mk(C_ALWAYS,     U_DONE,  1'b0, A_BT,       1'b0, ST_DONE);
            U_GD:      w = mk(C_BLK_BAD,    U_BAD,   1'b0, A_NONE,     1'b0, ST_DONE);
            U_GD_DO:   w = mk(C_NEVER,      U_IDLE,  1'b1, A_GD,       1'b1, ST_WAIT);
            U_PD:      w = mk(C_BLK_BAD,    U_BAD,   1'b0, A_NONE,     1'b0, ST_DONE);
            U_PD_INIT: w = mk(C_NEVER,      U_IDLE,  1'b0, A_PD_INIT,  1'b0, ST_DONE);
            U_PD_RD:   w = mk(C_NEVER,      U_IDLE,  1'b0, A_PD_RD,    1'b0, ST_DONE);
            U_PD_EM:   w = mk(C_PRINT_MORE, U_PD_RD, 1'b1, A_PD_NEXT,  1'b1, ST_PRINT);
            U_HALT:    w = mk(C_NEVER,      U_IDLE,  1'b1, A_NONE,     1'b1, ST_HALT);
            U_XR:      w = mk(C_OPND_BAD,   U_BAD,   1'b0, A_NONE,     1'b0, ST_DONE);
            U_XR_RD:   w = mk(C_NEVER,      U_IDLE,  1'b0, A_OP_RD,    1'b0, ST_DONE);
            U_XR_L:    w = mk(C_IS_L,       U_LR,    1'b0, A_NONE,     1'b0, ST_DONE);
            U_XR_S:    w = mk(C_IS_S,       U_SR,    1'b0, A_NONE,     1'b0, ST_DONE);
            U_CR:      w = mk(C_ALWAYS,     U_DONE,  1'b0, A_CR,       1'b0, ST_DONE);
            U_LR:      w = mk(C_NEVER,      U_IDLE,  1'b1, A_LR,       1'b1, ST_DONE);
            U_SR:      w = mk(C_NEVER,      U_IDLE,  1'b1, A_SR,       1'b1, ST_DONE);
            U_BAD:     w = mk(C_NEVER,      U_IDLE,  1'b1, A_NONE,     1'b1, ST_BAD);
            default:   w = mk(C_NEVER,      U_IDLE,  1'b1, A_NONE,     1'b0, ST_DONE);
        endcase
        return w;
    endfunction

    // Entry step for each item mode; unused modes only report done.
    function automatic t_upc dispatch(input logic [2:0] mode);
        t_upc e;
        unique case (mode)
            MODE_LOAD:  e = U_LD_CHK;
            MODE_START: e = U_ST;
            MODE_EXEC:  e = U_EX;
            MODE_CARD:  e = U_CD_CHK;
            MODE_CLEAR: e = U_CL;
            default:    e = U_DONE;
        endcase
        return e;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    // Ten times a decimal digit, as shifts and an add.
    function automatic logic [6:0] times_ten(input logic [3:0] d);
        return ({3'b000, d} << 3) + ({3'b000, d} << 1);
    endfunction

endpackage

// ===== sv/twm_sequencer.sv =====
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
// Depends on twm_pkg for the control word, conditions and the microprogram.
module twm_sequencer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [2:0]      i_mode,
    input  twm_pkg::t_flags i_flags,
    output logic            o_ready,
    output twm_pkg::t_ctrl  o_ctrl
);

    twm_pkg::t_upc   r_upc;
    twm_pkg::t_upc   n_upc;
    twm_pkg::t_uword w_uw;
    logic            w_idle;
    logic            w_go;
    logic            w_taken;

    assign w_uw   = twm_pkg::urom(r_upc);
    assign w_idle = (r_upc == twm_pkg::U_IDLE);

    // A step that emits waits until the output register is free.
    assign w_go    = !w_idle && (!w_uw.emit || i_flags.slot_free);
    assign o_ready = w_idle;

    assign o_ctrl.accept = w_idle && i_valid;
    assign o_ctrl.go     = w_go;
    assign o_ctrl.act    = w_uw.act;
    assign o_ctrl.emit   = w_uw.emit;
    assign o_ctrl.status = w_uw.status;

    // Jump condition select.
    always_comb begin
        unique case (w_uw.cond)
            twm_pkg::C_NEVER:      w_taken = 1'b0;
            twm_pkg::C_ALWAYS:     w_taken = 1'b1;
            twm_pkg::C_ADDR_BAD:   w_taken = i_flags.addr_bad;
            twm_pkg::C_PENDING:    w_taken = i_flags.pending;
            twm_pkg::C_IC_BAD:     w_taken = i_flags.ic_bad;
            twm_pkg::C_IS_GD:      w_taken = i_flags.is_gd;
            twm_pkg::C_IS_PD:      w_taken = i_flags.is_pd;
            twm_pkg::C_IS_H:       w_taken = i_flags.is_h;
            twm_pkg::C_IS_XR:      w_taken = i_flags.is_xr;
            twm_pkg::C_BT_SKIP:    w_taken = i_flags.bt_skip;
            twm_pkg::C_OPND_BAD:   w_taken = i_flags.opnd_bad;
            twm_pkg::C_BLK_BAD:    w_taken = i_flags.blk_bad;
            twm_pkg::C_CARD_FULL:  w_taken = i_flags.card_full;
            twm_pkg::C_PRINT_MORE: w_taken = i_flags.print_more;
            twm_pkg::C_IS_L:       w_taken = i_flags.is_l;
            twm_pkg::C_IS_S:       w_taken = i_flags.is_s;
        endcase
    end

    // Next step: dispatch on accept, jump, finish, fall through, or hold.
    always_comb begin
        n_upc = r_upc;
        priority if (w_idle && i_valid) begin
            n_upc = twm_pkg::dispatch(i_mode);
        end else if (w_go) begin
            priority if (w_taken) begin
                n_upc = w_uw.target;
            end else if (w_uw.fin) begin
                n_upc = twm_pkg::U_IDLE;
            end else begin
                n_upc = r_upc + twm_pkg::t_upc'(1);
            end
        end else begin
            n_upc = r_upc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= twm_pkg::U_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

endmodule

// ===== sv/twm_datapath.sv =====
// Datapath of the word machine: word memory, registers, decode flags, output register.
// Depends on twm_pkg; driven by the control struct from twm_sequencer.
module twm_datapath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  twm_pkg::t_ctrl  i_ctrl,
    input  logic [6:0]      i_address,
    input  logic [3:0]      i_card_index,
    input  logic [31:0]     i_word,
    input  logic            i_out_ready,
    output twm_pkg::t_flags o_flags,
    output logic            o_valid,
    output logic [2:0]      o_status,
    output logic [31:0]     o_out_word,
    output logic            o_last,
    output logic [6:0]      o_counter,
    output logic            o_compare_flag
);

    // Item registers, latched on accept.
    logic [6:0]  r_in_addr;
    logic [3:0]  r_in_idx;
    logic [31:0] r_in_word;

    // Machine state.
    logic [31:0]           r_gr;
    logic [6:0]            r_ic;
    logic                  r_toggle;
    logic [3:0]            r_blk;
    logic                  r_pending;
    twm_pkg::t_seen        r_seen;
    logic [31:0]           r_ir;
    logic [3:0]            r_pcnt;
    logic [6:0]            r_pbase;

    // Word memory with one valid bit per entry; an invalid entry reads as spaces.
    logic [31:0]                   r_mem [twm_pkg::MEM_WORDS];
    logic [twm_pkg::MEM_WORDS-1:0] r_mvalid;
    logic [31:0]                   r_rdata;
    logic                          r_rval;

    // Output register.
    logic        r_ovalid;
    logic [2:0]  r_ostatus;
    logic [31:0] r_oword;
    logic        r_olast;
    logic [6:0]  r_ocnt;
    logic        r_otog;

    logic [31:0] w_rdata;
    logic [6:0]  w_addr;
    logic        w_we;
    logic        w_re;
    logic [31:0] w_wdata;
    logic [31:0] w_load_word;
    logic [6:0]  w_opnd;
    logic [6:0]  w_tens;
    logic [7:0]  w_blk_end;
    logic [6:0]  w_card_addr;
    logic        w_idx_ok;
    logic        w_slot_free;
    logic        w_do;

    assign w_do    = i_ctrl.go;
    assign w_rdata = r_rval ? r_rdata : twm_pkg::SPACES;

    // A loaded word that starts with H is normalized to H000.
    assign w_load_word = (r_in_word[31:24] == twm_pkg::CH_H) ? twm_pkg::HALT_WORD : r_in_word;

    // Operand and block decode from the instruction register.
    assign w_tens      = twm_pkg::times_ten(r_ir[11:8]);
    assign w_opnd      = w_tens + {3'b000, r_ir[3:0]};
    assign w_blk_end   = {1'b0, w_tens} + 8'(twm_pkg::BLOCK_WORDS);
    assign w_card_addr = twm_pkg::times_ten(r_blk) + {3'b000, r_in_idx};
    assign w_idx_ok    = (r_in_idx < 4'(twm_pkg::BLOCK_WORDS));
    assign w_slot_free = !r_ovalid || i_out_ready;

    // Flags for the sequencer's jump conditions.
    always_comb begin
        o_flags.addr_bad   = (r_in_addr >= twm_pkg::MEM_LIMIT);
        o_flags.pending    = r_pending;
        o_flags.ic_bad     = (r_ic >= twm_pkg::MEM_LIMIT);
        o_flags.is_gd      = (r_ir[31:24] == twm_pkg::CH_G) && (r_ir[23:16] == twm_pkg::CH_D);
        o_flags.is_pd      = (r_ir[31:24] == twm_pkg::CH_P) && (r_ir[23:16] == twm_pkg::CH_D);
        o_flags.is_h       = (r_ir[31:24] == twm_pkg::CH_H);
        o_flags.is_xr      = ((r_ir[31:24] == twm_pkg::CH_L) || (r_ir[31:24] == twm_pkg::CH_S)
                              || (r_ir[31:24] == twm_pkg::CH_C))
                             && (r_ir[23:16] == twm_pkg::CH_R);
        o_flags.bt_skip    = !((r_ir[31:24] == twm_pkg::CH_B) && (r_ir[23:16] == twm_pkg::CH_T)
                               && r_toggle);
        o_flags.opnd_bad   = !twm_pkg::is_digit(r_ir[15:8]) || !twm_pkg::is_digit(r_ir[7:0])
                             || (w_opnd >= twm_pkg::MEM_LIMIT);
        o_flags.blk_bad    = !twm_pkg::is_digit(r_ir[15:8])
                             || (w_blk_end > 8'(twm_pkg::MEM_WORDS));
        o_flags.card_full  = (r_seen == '1);
        o_flags.print_more = (r_pcnt != 4'(twm_pkg::BLOCK_WORDS - 1));
        o_flags.is_l       = (r_ir[31:24] == twm_pkg::CH_L);
        o_flags.is_s       = (r_ir[31:24] == twm_pkg::CH_S);
        o_flags.slot_free  = w_slot_free;
    end

    // Memory port select: one access per step.
    always_comb begin
        w_addr  = r_ic;
        w_we    = 1'b0;
        w_re    = 1'b0;
        w_wdata = r_in_word;
        if (w_do) begin
            unique case (i_ctrl.act)
                twm_pkg::A_LOAD_WR: begin
                    w_addr  = r_in_addr;
                    w_we    = 1'b1;
                    w_wdata = w_load_word;
                end
                twm_pkg::A_CARD_WR: begin
                    w_addr  = w_card_addr;
                    w_we    = w_idx_ok;
                end
                twm_pkg::A_SR: begin
                    w_addr  = w_opnd;
                    w_we    = 1'b1;
                    w_wdata = r_gr;
                end
                twm_pkg::A_FETCH: begin
                    w_addr = r_ic;
                    w_re   = 1'b1;
                end
                twm_pkg::A_PD_RD: begin
                    w_addr = r_pbase + {3'b000, r_pcnt};
                    w_re   = 1'b1;
                end
                twm_pkg::A_OP_RD: begin
                    w_addr = w_opnd;
                    w_re   = 1'b1;
                end
                default: begin
                    w_we = 1'b0;
                end
            endcase
        end
    end

    // Memory array and registered read.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr[twm_pkg::MEM_AW-1:0]] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= r_mem[w_addr[twm_pkg::MEM_AW-1:0]];
        end
    end

    // Valid bits and the read-side valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvalid <= '0;
            r_rval   <= 1'b0;
        end else begin
            if (w_do && (i_ctrl.act == twm_pkg::A_CLEAR)) begin
                r_mvalid <= '0;
            end else if (w_we) begin
                r_mvalid[w_addr[twm_pkg::MEM_AW-1:0]] <= 1'b1;
            end
            if (w_re) begin
                r_rval <= r_mvalid[w_addr[twm_pkg::MEM_AW-1:0]];
            end
        end
    end

    // Item registers.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.accept) begin
            r_in_addr <= i_address;
            r_in_idx  <= i_card_index;
            r_in_word <= i_word;
        end
    end

    // Architectural registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gr      <= twm_pkg::SPACES;
            r_ic      <= '0;
            r_toggle  <= 1'b0;
            r_blk     <= '0;
            r_pending <= 1'b0;
            r_seen    <= '0;
        end else if (w_do) begin
            unique case (i_ctrl.act)
                twm_pkg::A_START: begin
                    r_ic      <= '0;
                    r_pending <= 1'b0;
                    r_seen    <= '0;
                end
                twm_pkg::A_CLEAR: begin
                    r_gr      <= twm_pkg::SPACES;
                    r_toggle  <= 1'b0;
                    r_pending <= 1'b0;
                    r_seen    <= '0;
                end
                twm_pkg::A_CARD_WR: begin
                    if (w_idx_ok) begin
                        r_seen <= r_seen | (twm_pkg::t_seen'(1) << r_in_idx);
                    end
                end
                twm_pkg::A_CARD_END: begin
                    r_pending <= 1'b0;
                    r_seen    <= '0;
                end
                twm_pkg::A_FETCH: begin
                    r_ic <= r_ic + 7'd1;
                end
                twm_pkg::A_GD: begin
                    r_blk     <= r_ir[11:8];
                    r_pending <= 1'b1;
                    r_seen    <= '0;
                end
                twm_pkg::A_LR: begin
                    r_gr <= w_rdata;
                end
                twm_pkg::A_CR: begin
                    r_toggle <= (w_rdata == r_gr);
                end
                twm_pkg::A_BT: begin
                    r_ic <= w_opnd;
                end
                default: begin
                    r_ic <= r_ic;
                end
            endcase
        end
    end

    // Instruction register and print block counters.
    always_ff @(posedge i_clk) begin
        if (w_do && (i_ctrl.act == twm_pkg::A_IR)) begin
            r_ir <= w_rdata;
        end
        if (w_do && (i_ctrl.act == twm_pkg::A_PD_INIT)) begin
            r_pbase <= w_tens;
            r_pcnt  <= '0;
        end else if (w_do && (i_ctrl.act == twm_pkg::A_PD_NEXT)) begin
            r_pcnt <= r_pcnt + 4'd1;
        end
    end

    // Output register: valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_do && i_ctrl.emit) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    // Output register: payload.
    always_ff @(posedge i_clk) begin
        if (w_do && i_ctrl.emit) begin
            r_ostatus <= i_ctrl.status;
            r_oword   <= (i_ctrl.status == twm_pkg::ST_PRINT) ? w_rdata : '0;
            r_olast   <= (i_ctrl.status == twm_pkg::ST_PRINT) && !o_flags.print_more;
            r_ocnt    <= r_ic;
            r_otog    <= r_toggle;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_status       = r_ostatus;
    assign o_out_word     = r_oword;
    assign o_last         = r_olast;
    assign o_counter      = r_ocnt;
    assign o_compare_flag = r_otog;

endmodule

// ===== sv/toy_word_machine_executor.sv =====
// Toy word machine executor. Each input item is run by a short microprogram over a
// single-port word memory, and a new item is taken only once the last one is done. Fetch,
// operand access and write-back share the one memory port, so they run as separate
// microprogram steps; a PD prints its ten words with one memory read and one output load
// per word. Results leave through an output register, so a step that emits waits
// only while that register holds an untaken item. After reset the memory reads as
// spaces at once through per-word valid bits; there is no clearing pass.
// Depends on twm_pkg, twm_sequencer, twm_datapath and the assertion macro header.
`include "toy_word_machine_executor_macros.svh"

module toy_word_machine_executor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // address[6:0], card_index[10:7], word[42:11], zeros
    input  logic [2:0]  s_axis_tuser,  // mode[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // out_word[31:0], counter[38:32], compare_flag[39]
    output logic [2:0]  m_axis_tuser,  // status[2:0]
    output logic        m_axis_tlast
);

    twm_pkg::t_ctrl  w_ctrl;
    twm_pkg::t_flags w_flags;
    logic [31:0]     w_out_word;
    logic [6:0]      w_counter;
    logic            w_compare_flag;

    // Step sequencer.
    twm_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_mode  (s_axis_tuser),
        .i_flags (w_flags),
        .o_ready (s_axis_tready),
        .o_ctrl  (w_ctrl)
    );

    // Memory, registers and output stage.
    twm_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (w_ctrl),
        .i_address      (s_axis_tdata[6:0]),
        .i_card_index   (s_axis_tdata[10:7]),
        .i_word         (s_axis_tdata[42:11]),
        .i_out_ready    (m_axis_tready),
        .o_flags        (w_flags),
        .o_valid        (m_axis_tvalid),
        .o_status       (m_axis_tuser),
        .o_out_word     (w_out_word),
        .o_last         (m_axis_tlast),
        .o_counter      (w_counter),
        .o_compare_flag (w_compare_flag)
    );

    assign m_axis_tdata = {w_compare_flag, w_counter, w_out_word};

    // An emitting step never overwrites a result that is still waiting.
    `TWM_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, w_ctrl.go && w_ctrl.emit, !m_axis_tvalid || m_axis_tready, "result overwritten")
    // After an item is accepted the sequencer is busy with it.
    `TWM_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready after accept")
    // The last mark only comes with a printed word.
    `TWM_ASSERT_NOW(a_last_is_print, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast, m_axis_tuser == twm_pkg::ST_PRINT, "last without print")
    // Only printed words carry data.
    `TWM_ASSERT_NOW(a_word_zero, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser != twm_pkg::ST_PRINT), m_axis_tdata[31:0] == 32'd0, "word on non-print result")

endmodule

// ===== tb/toy_word_machine_executor_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the toy word machine executor: keeps its own copy of the
// machine state, works out the results of every accepted item and compares them in order.
// Depends on twm_pkg for sizes, item modes, status codes and character constants.
module toy_word_machine_executor_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // address[6:0], card_index[10:7], word[42:11], zeros
    input  logic [2:0]  s_axis_tuser,  // mode[2:0]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,  // out_word[31:0], counter[38:32], compare_flag[39]
    input  logic [2:0]  m_axis_tuser,  // status[2:0]
    input  logic        m_axis_tlast,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);

    // One result item as the block should present it.
    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] word;
        logic        last;
        logic [6:0]  counter;
        logic        flag;
    } t_machine_result;

    // Machine state as the checker sees it.
    logic [31:0]     word_mem [twm_pkg::MEM_WORDS];
    logic [31:0]     acc_word;
    logic [6:0]      instr_ctr;
    logic            cmp_flag;
    logic [3:0]      card_blk;
    logic            card_open;
    twm_pkg::t_seen  cards_got;

    t_machine_result due_results[$];
    int fails   = 0;
    int checked = 0;

    // Queues one result stamped with the counter and flag as they stand now.
    task automatic post_result(input logic [2:0] status, input logic [31:0] word,
                               input logic last);
        t_machine_result r;
        r.status  = status;
        r.word    = word;
        r.last    = last;
        r.counter = instr_ctr;
        r.flag    = cmp_flag;
        due_results.push_back(r);
    endtask

    task automatic wipe_memory();
        for (int i = 0; i < twm_pkg::MEM_WORDS; i++) begin
            word_mem[i] = twm_pkg::SPACES;
        end
        acc_word  = twm_pkg::SPACES;
        cmp_flag  = 1'b0;
        card_open = 1'b0;
        cards_got = '0;
    endtask

    // Value of an ASCII digit, or -1 for any other character.
    function automatic int digit_value(input logic [7:0] c);
        return (c >= twm_pkg::CH_0 && c <= twm_pkg::CH_9) ? int'(c - twm_pkg::CH_0) : -1;
    endfunction

    // Two-digit operand address of an instruction, or -1 when it is unusable.
    function automatic int operand_index(input logic [31:0] ir);
        int t;
        int u;
        t = digit_value(ir[15:8]);
        u = digit_value(ir[7:0]);
        if (t < 0 || u < 0 || t * 10 + u >= twm_pkg::MEM_WORDS) begin
            return -1;
        end
        return t * 10 + u;
    endfunction

    // First word of the block named by the tens digit, or -1 when it does not fit.
    function automatic int block_base(input logic [31:0] ir);
        int d;
        d = digit_value(ir[15:8]);
        if (d < 0 || d * 10 + twm_pkg::BLOCK_WORDS > twm_pkg::MEM_WORDS) begin
            return -1;
        end
        return d * 10;
    endfunction

    // Fetches and runs one instruction.
    task automatic execute_word();
        logic [31:0] ir;
        logic [7:0]  op0;
        logic [7:0]  op1;
        int          a;
        if (card_open) begin
            post_result(twm_pkg::ST_WAIT, '0, 1'b0);
        end else if (int'(instr_ctr) >= twm_pkg::MEM_WORDS) begin
            post_result(twm_pkg::ST_BAD, '0, 1'b0);
        end else begin
            ir = word_mem[instr_ctr];
            instr_ctr = instr_ctr + 7'd1;
            op0 = ir[31:24];
            op1 = ir[23:16];
            if (op0 == twm_pkg::CH_G && op1 == twm_pkg::CH_D) begin
                a = block_base(ir);
                if (a < 0) begin
                    post_result(twm_pkg::ST_BAD, '0, 1'b0);
                end else begin
                    card_blk  = 4'(a / 10);
                    card_open = 1'b1;
                    cards_got = '0;
                    post_result(twm_pkg::ST_WAIT, '0, 1'b0);
                end
            end else if (op0 == twm_pkg::CH_P && op1 == twm_pkg::CH_D) begin
                a = block_base(ir);
                if (a < 0) begin
                    post_result(twm_pkg::ST_BAD, '0, 1'b0);
                end else begin
                    for (int i = 0; i < twm_pkg::BLOCK_WORDS; i++) begin
                        post_result(twm_pkg::ST_PRINT, word_mem[a + i],
                                    i == twm_pkg::BLOCK_WORDS - 1);
                    end
                end
            end else if (op0 == twm_pkg::CH_H) begin
                post_result(twm_pkg::ST_HALT, '0, 1'b0);
            end else if ((op0 == twm_pkg::CH_L || op0 == twm_pkg::CH_S
                          || op0 == twm_pkg::CH_C) && op1 == twm_pkg::CH_R) begin
                a = operand_index(ir);
                if (a < 0) begin
                    post_result(twm_pkg::ST_BAD, '0, 1'b0);
                end else begin
                    if (op0 == twm_pkg::CH_L) begin
                        acc_word = word_mem[a];
                    end else if (op0 == twm_pkg::CH_S) begin
                        word_mem[a] = acc_word;
                    end else begin
                        cmp_flag = (word_mem[a] == acc_word);
                    end
                    post_result(twm_pkg::ST_DONE, '0, 1'b0);
                end
            end else if (op0 == twm_pkg::CH_B && op1 == twm_pkg::CH_T && cmp_flag) begin
                a = operand_index(ir);
                if (a < 0) begin
                    post_result(twm_pkg::ST_BAD, '0, 1'b0);
                end else begin
                    instr_ctr = 7'(a);
                    post_result(twm_pkg::ST_DONE, '0, 1'b0);
                end
            end else begin
                // Unknown opcodes and a branch with the flag clear do nothing.
                post_result(twm_pkg::ST_DONE, '0, 1'b0);
            end
        end
    endtask

    // Applies one input item to the machine state and queues its results.
    task automatic machine_step(input logic [2:0] mode, input logic [6:0] addr,
                                input logic [3:0] idx, input logic [31:0] word);
        int slot;
        unique case (mode)
            twm_pkg::MODE_LOAD: begin
                if (int'(addr) >= twm_pkg::MEM_WORDS) begin
                    post_result(twm_pkg::ST_BAD, '0, 1'b0);
                end else begin
                    word_mem[addr] = (word[31:24] == twm_pkg::CH_H) ? twm_pkg::HALT_WORD
                                                                     : word;
                    post_result(twm_pkg::ST_DONE, '0, 1'b0);
                end
            end
            twm_pkg::MODE_START: begin
                instr_ctr = '0;
                card_open = 1'b0;
                cards_got = '0;
                post_result(twm_pkg::ST_DONE, '0, 1'b0);
            end
            twm_pkg::MODE_EXEC: begin
                execute_word();
            end
            twm_pkg::MODE_CARD: begin
                if (!card_open) begin
                    post_result(twm_pkg::ST_DONE, '0, 1'b0);
                end else begin
                    if (int'(idx) < twm_pkg::BLOCK_WORDS) begin
                        slot = int'(card_blk) * 10 + int'(idx);
                        if (slot < twm_pkg::MEM_WORDS) begin
                            word_mem[slot] = word;
                        end
                        cards_got[idx] = 1'b1;
                    end
                    // The block closes once every position has arrived.
                    if (&cards_got) begin
                        card_open = 1'b0;
                        cards_got = '0;
                        post_result(twm_pkg::ST_DONE, '0, 1'b0);
                    end else begin
                        post_result(twm_pkg::ST_WAIT, '0, 1'b0);
                    end
                end
            end
            twm_pkg::MODE_CLEAR: begin
                wipe_memory();
                post_result(twm_pkg::ST_DONE, '0, 1'b0);
            end
            default: begin
                post_result(twm_pkg::ST_DONE, '0, 1'b0);
            end
        endcase
    endtask

    task automatic match_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            fails++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // Results are compared before new items are applied, so an item accepted in the
    // same cycle can never be matched against a result that left earlier.
    always @(posedge i_clk) begin : watch
        t_machine_result got;
        t_machine_result want;
        if (!i_rst_n) begin
            wipe_memory();
            instr_ctr = '0;
            card_blk  = '0;
            due_results.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.status  = m_axis_tuser;
                got.word    = m_axis_tdata[31:0];
                got.last    = m_axis_tlast;
                got.counter = m_axis_tdata[38:32];
                got.flag    = m_axis_tdata[39];
                if (due_results.size() == 0) begin
                    fails++;
                    $display("%0t: result with nothing expected, expected none, got %0h",
                             $time, got);
                end else begin
                    want = due_results.pop_front();
                    match_field("status", want.status, got.status);
                    match_field("out_word", want.word, got.word);
                    match_field("last", want.last, got.last);
                    match_field("counter", want.counter, got.counter);
                    match_field("compare_flag", want.flag, got.flag);
                    checked++;
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                machine_step(s_axis_tuser, s_axis_tdata[6:0], s_axis_tdata[10:7],
                             s_axis_tdata[42:11]);
            end
        end
        o_fail_count <= fails;
        o_pending    <= due_results.size();
        o_checked    <= checked;
    end

endmodule

// ===== tb/toy_word_machine_executor_test.sv =====
`timescale 1ns / 100ps
// Testbench top for the toy word machine executor: drives programs, card blocks and
// random items with random gaps and back-pressure, and reports the verdict.
// Depends on twm_pkg, the executor RTL and toy_word_machine_executor_checker.
module toy_word_machine_executor_test;

    localparam logic [2:0] MODE_SPARE  = 3'd7;
    localparam int         ITEM_TARGET = 460;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;   // address[6:0], card_index[10:7], word[42:11], zeros
    logic [2:0]  s_axis_tuser;   // mode[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // out_word[31:0], counter[38:32], compare_flag[39]
    logic [2:0]  m_axis_tuser;   // status[2:0]
    logic        m_axis_tlast;

    int   fail_count;
    int   pending;
    int   checked;
    int   items_sent = 0;
    logic quiet      = 1'b0;

    toy_word_machine_executor dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    toy_word_machine_executor_checker result_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #10_000_000;
        $display("toy_word_machine_executor_test: FAIL");
        $finish;
    end

    function automatic logic [7:0] digit_char(input int n);
        return twm_pkg::CH_0 + 8'(n);
    endfunction

    function automatic logic [15:0] pair(input int n);
        return {digit_char(n / 10), digit_char(n % 10)};
    endfunction

    // Operand digits: mostly near the program, sometimes anywhere, now and then junk.
    function automatic logic [15:0] operand_chars();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return 16'($urandom);
        end
        if (r <= 6) begin
            return pair($urandom_range(0, 29));
        end
        return pair($urandom_range(0, 99));
    endfunction

    // A random instruction word, weighted toward the opcodes the machine knows.
    function automatic logic [31:0] random_instr();
        logic [7:0] tens;
        int         k;
        tens = digit_char(($urandom_range(0, 3) == 0) ? $urandom_range(0, 9)
                                                        : $urandom_range(0, 2));
        if ($urandom_range(0, 5) == 0) begin
            tens = 8'($urandom);
        end
        k = $urandom_range(0, 12);
        unique case (k)
            0, 1:   return {twm_pkg::CH_G, twm_pkg::CH_D, tens, 8'($urandom)};
            2, 3:   return {twm_pkg::CH_P, twm_pkg::CH_D, tens, 8'($urandom)};
            4, 5:   return {twm_pkg::CH_L, twm_pkg::CH_R, operand_chars()};
            6:      return {twm_pkg::CH_S, twm_pkg::CH_R, operand_chars()};
            7, 8:   return {twm_pkg::CH_C, twm_pkg::CH_R, operand_chars()};
            9, 10:  return {twm_pkg::CH_B, twm_pkg::CH_T, operand_chars()};
            11:     return {twm_pkg::CH_H, 24'($urandom)};
            default: begin
                if ($urandom_range(0, 1) == 0) begin
                    return {twm_pkg::CH_B, twm_pkg::CH_R, operand_chars()};
                end
            end
        endcase
        return $urandom;
    endfunction

    // Presents one item after a random gap and holds it until it is taken.
    // The valid stays high when the next item follows with no gap.
    task automatic send_item(input logic [2:0] mode, input logic [6:0] addr,
                             input logic [3:0] idx, input logic [31:0] word);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, word, idx, addr};
        s_axis_tuser  <= mode;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic load_word(input logic [6:0] addr, input logic [31:0] word);
        send_item(twm_pkg::MODE_LOAD, addr, 4'($urandom), word);
    endtask

    // Item whose unused fields carry random values.
    task automatic simple(input logic [2:0] mode);
        send_item(mode, 7'($urandom), 4'($urandom), $urandom);
    endtask

    task automatic exec_step();
        simple(twm_pkg::MODE_EXEC);
    endtask

    // Stops sending until every expected result has come back.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Ten card words in shuffled order, sometimes with repeats, stray indexes or
    // cut short.
    task automatic card_burst();
        int order [10];
        int stop;
        int j;
        int t;
        for (int i = 0; i < 10; i++) begin
            order[i] = i;
        end
        for (int i = 9; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        stop = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 9) : 10;
        for (int i = 0; i < stop; i++) begin
            if ($urandom_range(0, 7) == 0) begin
                send_item(twm_pkg::MODE_CARD, 7'($urandom), 4'($urandom_range(10, 15)),
                          $urandom);
            end
            if ($urandom_range(0, 7) == 0) begin
                send_item(twm_pkg::MODE_CARD, 7'($urandom), 4'(order[i]), $urandom);
            end
            send_item(twm_pkg::MODE_CARD, 7'($urandom), 4'(order[i]),
                      ($urandom_range(0, 1) == 0) ? random_instr() : $urandom);
        end
    endtask

    // Short hand-picked program that walks GD, PD, BT, CR, halt, an unknown opcode and the card cases.
    task automatic directed();
        simple(twm_pkg::MODE_CLEAR);
        simple(MODE_SPARE);
        send_item(twm_pkg::MODE_CARD, 7'd0, 4'd0, 32'hFFFF_FFFF);   // no block is waiting
        load_word(7'd127, 32'hFFFF_FFFF);                 // address out of range
        load_word(7'd0, {twm_pkg::CH_G, twm_pkg::CH_D, digit_char(1), twm_pkg::CH_0});
        load_word(7'd1, {twm_pkg::CH_P, twm_pkg::CH_D, digit_char(1), 8'h00});
        load_word(7'd2, {twm_pkg::CH_B, twm_pkg::CH_T, 8'h3F, 8'h3F});  // flag clear, junk
        load_word(7'd3, {twm_pkg::CH_C, twm_pkg::CH_R, digit_char(9), 8'hFF});
        load_word(7'd4, 32'h0000_0000);                   // unknown opcode
        load_word(7'd5, {twm_pkg::CH_H, 24'hFF_FFFF});    // stored as a plain halt
        simple(twm_pkg::MODE_START);
        exec_step();                                      // GD opens block 1
        exec_step();                                      // blocked by the open block
        send_item(twm_pkg::MODE_CARD, 7'd0, 4'd15, 32'h0);   // stray index
        for (int i = 0; i < 10; i++) begin
            send_item(twm_pkg::MODE_CARD, 7'd0, 4'(i),
                      (i == 0) ? 32'h0 : (i == 9) ? 32'hFFFF_FFFF : $urandom);
            if (i == 4) begin
                send_item(twm_pkg::MODE_CARD, 7'd0, 4'(i), $urandom);   // same slot again
            end
        end
        exec_step();                                      // PD prints block 1
        exec_step();
        exec_step();
        exec_step();
        exec_step();
    endtask

    // Loads a small random program, starts it and steps it, feeding card words
    // where the straight-line flow says a GD should be waiting.
    task automatic program_run();
        logic [31:0] prog [10];
        int          len;
        int          steps;
        int          pc;
        if ($urandom_range(0, 4) == 0) begin
            simple(twm_pkg::MODE_CLEAR);
        end
        len = $urandom_range(3, 10);
        for (int i = 0; i < len; i++) begin
            prog[i] = random_instr();
            load_word(7'(i), prog[i]);
        end
        repeat ($urandom_range(0, 4)) begin
            load_word(7'($urandom_range(10, 29)),
                      ($urandom_range(0, 1) == 0) ? random_instr() : $urandom);
        end
        simple(twm_pkg::MODE_START);
        steps = len + $urandom_range(0, 5);
        pc = 0;
        repeat (steps) begin
            exec_step();
            if (pc < len && prog[pc][31:16] == {twm_pkg::CH_G, twm_pkg::CH_D}
                && $urandom_range(0, 5) != 0) begin
                card_burst();
            end
            pc++;
        end
    endtask

    // Branches to the top of memory so the counter runs past the last word.
    task automatic far_end();
        if ($urandom_range(0, 3) != 0) begin
            simple(twm_pkg::MODE_CLEAR);
        end
        load_word(7'd0, {twm_pkg::CH_C, twm_pkg::CH_R, pair($urandom_range(50, 89))});
        load_word(7'd1, {twm_pkg::CH_B, twm_pkg::CH_T, pair($urandom_range(94, 99))});
        for (int a = 94; a < 100; a++) begin
            load_word(7'(a), ($urandom_range(0, 2) == 0) ? random_instr() : twm_pkg::SPACES);
        end
        simple(twm_pkg::MODE_START);
        repeat ($urandom_range(4, 9)) exec_step();
    endtask

    task automatic noise();
        repeat ($urandom_range(3, 10)) begin
            send_item(3'($urandom), 7'($urandom), 4'($urandom), $urandom);
        end
    endtask

    // Result side: random stalls before each item, none while quiet.
    initial begin : result_sink
        int gap;
        m_axis_tready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            gap = quiet ? 0 : $urandom_range(0, 13);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    // Stimulus and verdict.
    initial begin : stimulus
        int r;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed();
        drain();

        while (items_sent < ITEM_TARGET) begin
            quiet = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 9);
            if (r < 7) begin
                program_run();
            end else if (r < 8) begin
                far_end();
            end else begin
                noise();
            end
            if ($urandom_range(0, 7) == 0) begin
                drain();
            end
        end

        quiet = 1'b0;
        drain();
        repeat (40) @(posedge i_clk);

        $display("Sent %0d items: hand-picked program, random programs with card blocks,",
                 items_sent);
        $display("branches to the top of memory and random items; %0d results compared.",
                 checked);
        if (fail_count == 0) begin
            $display("toy_word_machine_executor_test: PASS");
        end else begin
            $display("toy_word_machine_executor_test: FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/twm_pkg.sv
sv/twm_sequencer.sv
sv/twm_datapath.sv
sv/toy_word_machine_executor.sv
tb/toy_word_machine_executor_checker.sv
tb/toy_word_machine_executor_test.sv
